// ----- hw/rtl/polar_grid_bilinear_beam_unit_assert.svh -----
// Assertion macros used by the checker file.
`ifndef POLAR_GRID_BILINEAR_BEAM_UNIT_ASSERT_SVH
`define POLAR_GRID_BILINEAR_BEAM_UNIT_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define PGB_ASSERT_IMP(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("assertion failed");
// Implication whose consequent is checked in the next cycle.
`define PGB_ASSERT_NEXT(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("assertion failed");
`endif

// ----- hw/rtl/pgb_pkg.sv -----
`timescale 1ns / 1ps
package pgb_pkg;
  localparam int THETA_ROWS = 64;
  localparam int PHI_COLS = 64;
  localparam int ROW_W = $clog2(THETA_ROWS);
  localparam int COL_W = $clog2(PHI_COLS);
  localparam int ADDR_W = ROW_W + COL_W;
  localparam int CELLS = THETA_ROWS * PHI_COLS;

  localparam logic [2:0] REG_THETA_ROWS = 3'd0;
  localparam logic [2:0] REG_PHI_COLS = 3'd1;
  localparam logic [2:0] REG_ANGLE_STEP = 3'd2;
  localparam logic [2:0] REG_THETA_SCALE = 3'd3;
  localparam logic [2:0] REG_THETA_LIMIT = 3'd4;
  localparam logic [2:0] REG_POL_ENABLE = 3'd5;

  localparam logic CMD_QUERY = 1'b0;
  localparam logic CMD_LOAD = 1'b1;

  typedef struct packed {
    logic command;
    logic [21:0] theta;
    logic [15:0] phi;
    logic [15:0] psi;
    logic [5:0] cell_row;
    logic [5:0] cell_col;
    logic signed [31:0] cell_intensity;
    logic signed [31:0] cell_q;
    logic signed [31:0] cell_u;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] scalar_out;
    logic signed [31:0] pol_out;
  } out_item_t;

  // Work handed from front to back: either a cell write or a lookup.
  typedef struct packed {
    logic is_load;
    logic zero;
    logic pol;
    logic [ADDR_W-1:0] addr_a;
    logic [ADDR_W-1:0] addr_b;
    logic [ADDR_W-1:0] addr_c;
    logic [ADDR_W-1:0] addr_d;
    logic [15:0] fp;
    logic [16:0] ft;
    logic [15:0] psi_a2;
    logic signed [31:0] wi;
    logic signed [31:0] wq;
    logic signed [31:0] wu;
  } job_t;

  typedef struct packed {
    logic [6:0] rows;
    logic [6:0] cols;
    logic [15:0] step;
    logic [23:0] scale;
    logic [21:0] limit;
    logic pol_en;
  } cfg_t;

  typedef enum logic [1:0] {BK_IDLE, BK_READ2, BK_WAIT} bk_state_t;

  typedef logic [256:0][15:0] sin_rom_t;

  function automatic logic [15:0] quarter_rom(input logic [8:0] k);
    logic [63:0] x, x2, p, y, r;
    begin
      x = 64'(k) << 8;
      x2 = (x * x) >> 16;
      p = 64'd5027045;
      p = 64'd85569278 - ((x2 * p) >> 16);
      p = 64'd693598671 - ((x2 * p) >> 16);
      p = 64'd1686629713 - ((x2 * p) >> 16);
      y = (x * p) >> 16;
      r = (y * 64'd32767 + (64'd1 << 29)) >> 30;
      if (r > 64'd32767) r = 64'd32767;
      quarter_rom = r[15:0];
    end
  endfunction

  // The quarter wave is evaluated once at elaboration and kept as a constant table.
  function automatic sin_rom_t build_sin_rom();
    sin_rom_t t;
    for (int k = 0; k < 257; k++) t[k] = quarter_rom(9'(k));
    return t;
  endfunction

  localparam sin_rom_t SIN_ROM = build_sin_rom();

  function automatic logic signed [16:0] sine16(input logic [15:0] angle);
    logic [9:0] idx;
    logic [8:0] k;
    logic signed [16:0] v;
    begin
      idx = angle[15:6];
      k = {1'b0, idx[7:0]};
      if (idx[8]) k = 9'd256 - k;
      v = 17'(signed'({1'b0, SIN_ROM[k]}));
      sine16 = idx[9] ? -v : v;
    end
  endfunction

  function automatic logic signed [16:0] cosine16(input logic [15:0] angle);
    cosine16 = sine16(angle + 16'd16384);
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
    if (v > 50'sd2147483647) sat32 = 32'h7fffffff;
    else if (v < -50'sd2147483648) sat32 = 32'h80000000;
    else sat32 = v[31:0];
  endfunction
endpackage

// ----- hw/rtl/polar_grid_bilinear_beam_unit.sv -----
`timescale 1ns / 1ps
// Polar-grid beam lookup. A load request writes one cell of the intensity, Q and U
// tables (Q and U rotated by twice the column angle) and gives no result; a query
// request gives one result. The front part registers requests and forms addresses
// and weights in two register stages that can hold two requests; the back part reads
// the four neighbour cells two at a time on the dual-port table memories, a and b
// first and then c and d, so a query takes two reads and a load one write. A result
// passes the r, m and p stages to the output register; a stalled result holds the
// whole back part. Cells never loaded read as undefined. The user must write
// configuration only while idle; the block itself does not enforce it.
module polar_grid_bilinear_beam_unit (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  pgb_pkg::in_item_t in_data,
  output logic out_valid,
  input  logic out_ready,
  output pgb_pkg::out_item_t out_data,
  input  logic cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [23:0] cfg_data
);
  pgb_pkg::cfg_t cfg;
  logic fj_valid, fj_ready;
  pgb_pkg::job_t fj;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.rows <= 7'd64;
      cfg.cols <= 7'd64;
      cfg.step <= 16'd1024;
      cfg.scale <= 24'd65536;
      cfg.limit <= 22'd0;
      cfg.pol_en <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pgb_pkg::REG_THETA_ROWS: cfg.rows <= cfg_data[6:0];
        pgb_pkg::REG_PHI_COLS: cfg.cols <= cfg_data[6:0];
        pgb_pkg::REG_ANGLE_STEP: cfg.step <= cfg_data[15:0];
        pgb_pkg::REG_THETA_SCALE: cfg.scale <= cfg_data;
        pgb_pkg::REG_THETA_LIMIT: cfg.limit <= cfg_data[21:0];
        pgb_pkg::REG_POL_ENABLE: cfg.pol_en <= cfg_data[0];
        default: ;
      endcase
    end
  end

  pgb_front u_front (.clk, .rst, .cfg, .in_valid, .in_ready, .in_item(in_data),
    .job_valid(fj_valid), .job_ready(fj_ready), .job(fj));
  pgb_back u_back (.clk, .rst, .job_valid(fj_valid), .job_ready(fj_ready), .job(fj),
    .out_valid, .out_ready, .out_item(out_data));
endmodule

// ----- hw/rtl/pgb_ram.sv -----
`timescale 1ns / 1ps
module pgb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic clk,
  input  logic we,
  input  logic re,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0] rdata_a,
  output logic [WIDTH-1:0] rdata_b
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end
endmodule

// ----- hw/rtl/pgb_front.sv -----
`timescale 1ns / 1ps
module pgb_front (
  input  logic clk,
  input  logic rst,
  input  pgb_pkg::cfg_t cfg,
  input  logic in_valid,
  output logic in_ready,
  input  pgb_pkg::in_item_t in_item,
  output logic job_valid,
  input  logic job_ready,
  output pgb_pkg::job_t job
);
  // Stage 1 registers the request and starts the products; stage 2 builds the job.
  logic s1_valid;
  pgb_pkg::in_item_t s1;
  logic [45:0] tprod;
  logic [22:0] fphi;
  logic signed [16:0] c1, sn1;
  logic [6:0] nth, nph;
  logic s2_valid;
  pgb_pkg::job_t s2;
  pgb_pkg::job_t j;
  logic adv2, adv1;
  logic [15:0] pshift, ang;
  logic [31:0] angp;
  logic [6:0] iphi, iphi1;
  logic [17:0] itheta;
  logic signed [49:0] nq, nu;

  assign adv2 = !s2_valid || job_ready;
  assign adv1 = !s1_valid || adv2;
  assign in_ready = adv1;
  assign job_valid = s2_valid;
  assign job = s2;

  always_comb begin
    nth = cfg.rows;
    if (nth < 7'd2) nth = 7'd2;
    if (nth > 7'(pgb_pkg::THETA_ROWS)) nth = 7'(pgb_pkg::THETA_ROWS);
    nph = cfg.cols;
    if (nph < 7'd1) nph = 7'd1;
    if (nph > 7'(pgb_pkg::PHI_COLS)) nph = 7'(pgb_pkg::PHI_COLS);
  end

  always_comb begin
    pshift = in_item.phi + 16'd32768;
    angp = 32'(in_item.cell_col) * 32'(cfg.step);
    ang = {angp[14:0], 1'b0};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      if (adv1) s1_valid <= in_valid;
      if (adv2) s2_valid <= s1_valid && !(s1.command == pgb_pkg::CMD_LOAD &&
        (32'(s1.cell_row) >= pgb_pkg::THETA_ROWS || 32'(s1.cell_col) >= pgb_pkg::PHI_COLS));
    end
    if (adv1) begin
      s1 <= in_item;
      fphi <= 23'(pshift * nph);
      tprod <= 46'(in_item.theta * cfg.scale);
      c1 <= pgb_pkg::cosine16(ang);
      sn1 <= pgb_pkg::sine16(ang);
    end
    if (adv2) s2 <= j;
  end

  always_comb begin
    j = '0;
    j.is_load = (s1.command == pgb_pkg::CMD_LOAD);
    j.zero = (s1.theta >= cfg.limit);
    j.pol = cfg.pol_en;
    iphi = fphi[22:16];
    if (iphi >= nph) iphi = 7'd0;
    iphi1 = iphi + 7'd1;
    if (iphi1 >= nph) iphi1 = 7'd0;
    j.fp = fphi[15:0];
    itheta = tprod[45:28];
    j.ft = {1'b0, tprod[27:12]};
    if (itheta > 18'(nth - 7'd2)) begin
      itheta = 18'(nth - 7'd2);
      j.ft = 17'h10000;
    end
    j.psi_a2 = (16'd0 - s1.psi - s1.phi) << 1;
    j.addr_a = {itheta[pgb_pkg::ROW_W-1:0], iphi[pgb_pkg::COL_W-1:0]};
    j.addr_b = {itheta[pgb_pkg::ROW_W-1:0], iphi1[pgb_pkg::COL_W-1:0]};
    j.addr_c = {itheta[pgb_pkg::ROW_W-1:0] + 1'b1, iphi[pgb_pkg::COL_W-1:0]};
    j.addr_d = {itheta[pgb_pkg::ROW_W-1:0] + 1'b1, iphi1[pgb_pkg::COL_W-1:0]};
    nq = -(50'(s1.cell_q) * c1) - 50'(s1.cell_u) * sn1 + 50'sd16384;
    nu = 50'(s1.cell_q) * sn1 - 50'(s1.cell_u) * c1 + 50'sd16384;
    if (j.is_load) begin
      j.addr_a = {s1.cell_row[pgb_pkg::ROW_W-1:0], s1.cell_col[pgb_pkg::COL_W-1:0]};
      j.wi = s1.cell_intensity;
      j.wq = pgb_pkg::sat32(nq >>> 15);
      j.wu = pgb_pkg::sat32(nu >>> 15);
    end
  end
endmodule

// ----- hw/rtl/pgb_back.sv -----
`timescale 1ns / 1ps
module pgb_back (
  input  logic clk,
  input  logic rst,
  input  logic job_valid,
  output logic job_ready,
  input  pgb_pkg::job_t job,
  output logic out_valid,
  input  logic out_ready,
  output pgb_pkg::out_item_t out_item
);
  // Two reads per lookup (cells a,b then c,d); math runs behind.
  pgb_pkg::bk_state_t state, state_next;
  logic we, re, second;
  logic [pgb_pkg::ADDR_W-1:0] ra, rb;
  logic [31:0] i0, i1, q0, q1, u0, u1;
  logic r_valid, r_second;
  pgb_pkg::job_t r_job;
  logic signed [31:0] ilo, qlo, ulo, ihi, qhi, uhi;
  logic m_valid;
  pgb_pkg::job_t m_job;
  logic p_valid;
  pgb_pkg::job_t p_job;
  logic signed [31:0] pi, pq, pu;
  logic signed [16:0] pc, ps;
  logic stall;
  logic o_valid;
  pgb_pkg::out_item_t o_item;
  logic signed [49:0] pacc;

  function automatic logic signed [31:0] lerp(input logic signed [31:0] lo,
      input logic signed [31:0] hi, input logic [16:0] f);
    logic signed [50:0] acc;
    begin
      acc = 51'(lo) * 51'(signed'({1'b0, 17'h10000 - f})) +
            51'(hi) * 51'(signed'({1'b0, f})) + 51'sd32768;
      lerp = pgb_pkg::sat32(50'(acc >>> 16));
    end
  endfunction

  // Pipeline advances only when the output register can take a result.
  assign stall = o_valid && !out_ready;
  assign re = !stall;
  assign out_valid = o_valid;
  assign out_item = o_item;

  always_ff @(posedge clk) begin
    if (rst) state <= pgb_pkg::BK_IDLE;
    else if (!stall) state <= state_next;
  end

  always_comb begin
    state_next = state;
    job_ready = 1'b0;
    second = 1'b0;
    we = 1'b0;
    ra = job.addr_a;
    rb = job.addr_b;
    unique case (state)
      pgb_pkg::BK_IDLE, pgb_pkg::BK_WAIT: begin
        if (!stall && job_valid) begin
          if (job.is_load) begin
            job_ready = 1'b1;
            we = 1'b1;
            state_next = pgb_pkg::BK_IDLE;
          end else state_next = pgb_pkg::BK_READ2;
        end
      end
      pgb_pkg::BK_READ2: begin
        ra = job.addr_c;
        rb = job.addr_d;
        second = 1'b1;
        if (!stall) begin
          job_ready = 1'b1;
          state_next = pgb_pkg::BK_IDLE;
        end
      end
      default: state_next = pgb_pkg::BK_IDLE;
    endcase
  end

  pgb_ram #(.WIDTH(32), .DEPTH(pgb_pkg::CELLS)) u_iram (.clk, .we, .re, .waddr(job.addr_a),
    .wdata(job.wi), .raddr_a(ra), .raddr_b(rb), .rdata_a(i0), .rdata_b(i1));
  pgb_ram #(.WIDTH(32), .DEPTH(pgb_pkg::CELLS)) u_qram (.clk, .we, .re, .waddr(job.addr_a),
    .wdata(job.wq), .raddr_a(ra), .raddr_b(rb), .rdata_a(q0), .rdata_b(q1));
  pgb_ram #(.WIDTH(32), .DEPTH(pgb_pkg::CELLS)) u_uram (.clk, .we, .re, .waddr(job.addr_a),
    .wdata(job.wu), .raddr_a(ra), .raddr_b(rb), .rdata_a(u0), .rdata_b(u1));

  always_comb begin
    pacc = 50'(pq) * pc + 50'(pu) * ps + 50'sd16384;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      r_valid <= 1'b0;
      m_valid <= 1'b0;
      p_valid <= 1'b0;
      o_valid <= 1'b0;
    end else if (!stall) begin
      r_valid <= (state == pgb_pkg::BK_READ2) ||
                 ((state != pgb_pkg::BK_READ2) && job_valid && !job.is_load);
      m_valid <= r_valid && r_second;
      p_valid <= m_valid;
      o_valid <= p_valid;
    end
    if (!stall) begin
      r_second <= second;
      r_job <= job;
      if (r_valid && !r_second) begin
        ilo <= lerp(i0, i1, {1'b0, r_job.fp});
        qlo <= lerp(q0, q1, {1'b0, r_job.fp});
        ulo <= lerp(u0, u1, {1'b0, r_job.fp});
      end
      ihi <= lerp(i0, i1, {1'b0, r_job.fp});
      qhi <= lerp(q0, q1, {1'b0, r_job.fp});
      uhi <= lerp(u0, u1, {1'b0, r_job.fp});
      m_job <= r_job;
      pi <= lerp(ilo, ihi, m_job.ft);
      pq <= lerp(qlo, qhi, m_job.ft);
      pu <= lerp(ulo, uhi, m_job.ft);
      pc <= pgb_pkg::cosine16(m_job.psi_a2);
      ps <= pgb_pkg::sine16(m_job.psi_a2);
      p_job <= m_job;
      if (p_valid) begin
        o_item.scalar_out <= p_job.zero ? 32'sd0 : pi;
        o_item.pol_out <= (p_job.zero || !p_job.pol) ? 32'sd0 :
                          pgb_pkg::sat32(pacc >>> 15);
      end
    end
  end
endmodule

// ----- hw/rtl/pgb_checker.sv -----
`timescale 1ns / 1ps
`include "polar_grid_bilinear_beam_unit_assert.svh"
module pgb_checker (
  input logic clk,
  input logic rst,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input pgb_pkg::out_item_t out_data
);
  `PGB_ASSERT_NEXT(out_hold, clk, rst, out_valid && !out_ready, out_valid)
  `PGB_ASSERT_NEXT(out_stable, clk, rst, out_valid && !out_ready, $stable(out_data))
  `PGB_ASSERT_NEXT(rst_clears_out, clk, 1'b0, rst, !out_valid)
  `PGB_ASSERT_NEXT(rst_gives_ready, clk, 1'b0, rst, in_ready)
endmodule

bind polar_grid_bilinear_beam_unit pgb_checker u_pgb_checker (.clk, .rst,
  .in_ready, .out_valid, .out_ready, .out_data);
